// ----- hdl/ptp_pkg.sv -----
package ptp_pkg;

  localparam int unsigned MAX_LEN  = 64;
  localparam int unsigned IDX_W    = $clog2(MAX_LEN);
  localparam int unsigned LEN_W    = IDX_W + 1;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ROUNDS_W = 31;

  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  typedef enum logic [1:0] {
    KIND_ENTRY  = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_ENCODE = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_BLD_RD,
    ST_BLD_WR,
    ST_CHK,
    ST_MUL_RD,
    ST_MUL_IX,
    ST_MUL_WR,
    ST_SQR_RD,
    ST_SQR_IX,
    ST_SQR_WR,
    ST_OUT_RD,
    ST_OUT_IX,
    ST_OUT_WR
  } state_e;

  typedef struct packed {
    logic [1:0]          kind;
    logic [IDX_W-1:0]    position;
    logic [LEN_W-1:0]    target;
    logic [BYTE_W-1:0]   byte_in;
    logic [ROUNDS_W-1:0] rounds;
  } ptp_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              last;
  } ptp_out_t;

endpackage

// ----- hdl/permutation_power_transposer.sv -----
// Permutation-power transposition cipher. Words on the input channel carry a
// kind: 0 writes one permutation entry (source position -> 1-based target),
// 1 appends a message byte (dropped once block_length bytes are held), 2
// encodes: positions never written are padded with spaces, the permutation
// is applied "rounds" times and block_length bytes leave in position order
// with last set on the final one; the message pointer then clears. Kind 0
// and 1 words do not stall the input and may follow back to back. An encode
// holds in_stall_o high through setup, the multiplies, the squarings and the
// output; the power is built by square-and-multiply, so there is one
// squaring per significant bit of rounds beyond the top one and one
// multiply per set bit. Each element of a pass chains two reads of
// registered-output memories before its write. The output register lets
// the next word enter while the last byte still waits on out_stall_i.
// block_length is to be written through cfg_we_i only while idle; the block
// does not enforce this. 0 acts as 1, above 64 as 64.
module permutation_power_transposer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptp_pkg::ptp_in_t   in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptp_pkg::ptp_out_t  out_word_o,
  input  logic               cfg_we_i,
  input  logic [ptp_pkg::LEN_W-1:0] cfg_data_i
);

  import ptp_pkg::*;

  state_e state_q, state_d;

  logic [LEN_W-1:0]    blk_len_q;
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    len_dec;
  logic [IDX_W-1:0]    last_idx;
  logic                idx_last;

  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                cur_q, cur_d;      // which smap bank holds the current step map
  logic [LEN_W-1:0]    wp_q, wp_d;
  logic [ROUNDS_W-1:0] rounds_q, rounds_d;
  logic [IDX_W-1:0]    p_q, p_d;
  logic                hit_q, hit_d;
  logic                out_valid_q, out_valid_d;
  ptp_out_t            out_word_q, out_word_d;

  logic [LEN_W-1:0]    tgt_dec;

  // memory ports
  logic                perm_we;
  logic [IDX_W-1:0]    perm_rdata;
  logic                msg_we;
  logic [IDX_W-1:0]    msg_raddr;
  logic [BYTE_W-1:0]   msg_rdata;
  logic                smap_we;
  logic [IDX_W:0]      smap_waddr;
  logic [IDX_W-1:0]    smap_wdata;
  logic [IDX_W:0]      smap_raddr;
  logic [IDX_W-1:0]    smap_rdata;
  logic                pmap_we;
  logic [IDX_W-1:0]    pmap_wdata;
  logic [IDX_W-1:0]    pmap_rdata;

  // effective block length, clamped to 1..MAX_LEN
  always_comb begin
    if (blk_len_q == '0) begin
      len = LEN_W'(1);
    end else if (blk_len_q > LEN_W'(MAX_LEN)) begin
      len = LEN_W'(MAX_LEN);
    end else begin
      len = blk_len_q;
    end
  end

  assign len_dec  = len - LEN_W'(1);
  assign last_idx = len_dec[IDX_W-1:0];
  assign idx_last = (idx_q == last_idx);
  assign tgt_dec  = in_word_i.target - LEN_W'(1);

  // Permutation table: entry i holds target(i)-1.
  ptp_ram #(.Depth(MAX_LEN), .Width(IDX_W)) u_perm (
    .clk_i   (clk_i),
    .we_i    (perm_we),
    .waddr_i (in_word_i.position),
    .wdata_i (tgt_dec[IDX_W-1:0]),
    .raddr_i (idx_q),
    .rdata_o (perm_rdata)
  );

  // Message bytes in append order.
  ptp_ram #(.Depth(MAX_LEN), .Width(BYTE_W)) u_msg (
    .clk_i   (clk_i),
    .we_i    (msg_we),
    .waddr_i (wp_q[IDX_W-1:0]),
    .wdata_i (in_word_i.byte_in),
    .raddr_i (msg_raddr),
    .rdata_o (msg_rdata)
  );

  // Step map, two banks: squaring reads one bank and writes the other.
  // smap[i] = source position of the byte landing at i after one step.
  ptp_ram #(.Depth(2 * MAX_LEN), .Width(IDX_W)) u_smap (
    .clk_i   (clk_i),
    .we_i    (smap_we),
    .waddr_i (smap_waddr),
    .wdata_i (smap_wdata),
    .raddr_i (smap_raddr),
    .rdata_o (smap_rdata)
  );

  // Accumulated power map; updated in place, read and write of entry i
  // fall in different phases of the same element.
  ptp_ram #(.Depth(MAX_LEN), .Width(IDX_W)) u_pmap (
    .clk_i   (clk_i),
    .we_i    (pmap_we),
    .waddr_i (idx_q),
    .wdata_i (pmap_wdata),
    .raddr_i (idx_q),
    .rdata_o (pmap_rdata)
  );

  // Sequencer. Phases of one element never overlap, so no access to an
  // entry can race a write of the same entry.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    wp_d        = wp_q;
    rounds_d    = rounds_q;
    p_d         = p_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_word_d  = out_word_q;

    perm_we     = 1'b0;
    msg_we      = 1'b0;
    msg_raddr   = p_q;
    smap_we     = 1'b0;
    smap_waddr  = {cur_q, idx_q};
    smap_wdata  = idx_q;
    smap_raddr  = {cur_q, idx_q};
    pmap_we     = 1'b0;
    pmap_wdata  = idx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_word_i.kind)
            KIND_ENTRY: begin
              perm_we = 1'b1;
            end
            KIND_BYTE: begin
              if (wp_q < len) begin
                msg_we = 1'b1;
                wp_d   = wp_q + LEN_W'(1);
              end
            end
            KIND_ENCODE: begin
              rounds_d = in_word_i.rounds;
              idx_d    = '0;
              state_d  = ST_INIT;
            end
            default: ;
          endcase
        end
      end

      // identity into step map and power map
      ST_INIT: begin
        smap_we = 1'b1;
        pmap_we = 1'b1;
        if (idx_last) begin
          idx_d   = '0;
          state_d = ST_BLD_RD;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      ST_BLD_RD: state_d = ST_BLD_WR;

      // invert the table; ascending order so a later source wins
      ST_BLD_WR: begin
        if ({1'b0, perm_rdata} < len) begin
          smap_we    = 1'b1;
          smap_waddr = {cur_q, perm_rdata};
        end
        if (idx_last) begin
          idx_d   = '0;
          state_d = ST_CHK;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_BLD_RD;
        end
      end

      ST_CHK: begin
        if (rounds_q == '0) begin
          state_d = ST_OUT_RD;
        end else if (rounds_q[0]) begin
          state_d = ST_MUL_RD;
        end else begin
          state_d = ST_SQR_RD;
        end
      end

      // power[i] = step[power[i]]
      ST_MUL_RD: state_d = ST_MUL_IX;
      ST_MUL_IX: begin
        smap_raddr = {cur_q, pmap_rdata};
        state_d    = ST_MUL_WR;
      end
      ST_MUL_WR: begin
        pmap_we    = 1'b1;
        pmap_wdata = smap_rdata;
        if (idx_last) begin
          idx_d = '0;
          if (rounds_q[ROUNDS_W-1:1] == '0) begin
            rounds_d = '0;          // last bit: no squaring needed
            state_d  = ST_CHK;
          end else begin
            state_d = ST_SQR_RD;
          end
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_MUL_RD;
        end
      end

      // next[i] = step[step[i]] into the other bank
      ST_SQR_RD: state_d = ST_SQR_IX;
      ST_SQR_IX: begin
        smap_raddr = {cur_q, smap_rdata};
        state_d    = ST_SQR_WR;
      end
      ST_SQR_WR: begin
        smap_we    = 1'b1;
        smap_waddr = {~cur_q, idx_q};
        smap_wdata = smap_rdata;
        if (idx_last) begin
          idx_d    = '0;
          cur_d    = ~cur_q;
          rounds_d = rounds_q >> 1;
          state_d  = ST_CHK;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_SQR_RD;
        end
      end

      // byte i = message[power[i]], space where never appended
      ST_OUT_RD: state_d = ST_OUT_IX;
      ST_OUT_IX: begin
        msg_raddr = pmap_rdata;
        p_d       = pmap_rdata;
        hit_d     = ({1'b0, pmap_rdata} < wp_q);
        state_d   = ST_OUT_WR;
      end
      ST_OUT_WR: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_word_d.byte_out = hit_q ? msg_rdata : SPACE_CHAR;
          out_word_d.last     = idx_last;
          if (idx_last) begin
            idx_d   = '0;
            wp_d    = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_OUT_RD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cur_q       <= 1'b0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
      blk_len_q   <= LEN_W'(MAX_LEN);
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cur_q       <= cur_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        blk_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rounds_q   <= rounds_d;
    p_q        <= p_d;
    hit_q      <= hit_d;
    out_word_q <= out_word_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- hdl/ptp_ram.sv -----
module ptp_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ptp_checker.sv -----
module ptp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input ptp_pkg::ptp_in_t   in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ptp_pkg::ptp_out_t  out_word_o,
  input logic               cfg_we_i,
  input logic [ptp_pkg::LEN_W-1:0] cfg_data_i
);

  import ptp_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // table and byte writes do not stall the input
  a_short_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_word_i.kind != KIND_ENCODE) |=> !in_stall_o)
    else $error("input stalled after a single-cycle word");

  // an encode occupies the block
  a_encode_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_word_i.kind == KIND_ENCODE) |=> in_stall_o)
    else $error("input not stalled after encode");

  // results only come out of an encode in progress
  a_out_from_encode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word without an encode");

endmodule

bind permutation_power_transposer ptp_checker u_ptp_checker (.*);
